[rtl/adam_pkg.sv]
package adam_pkg;

  localparam int NUM_COEFS  = 64;
  localparam int SLOT_W     = 6;
  localparam int VAL_W      = 32;
  localparam int LR_W       = 24;
  localparam int DECAY_W    = 16;
  localparam int EPS_W      = 24;
  localparam int NU_W       = 48;
  localparam int IDX_W      = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // square root: radicand is nu * 2^14, two digits per cycle
  localparam int SQ_SHIFT   = 14;
  localparam int SQ_IN_W    = 64;
  localparam int ROOT_W     = SQ_IN_W / 2;
  localparam int SQ_REM_W   = ROOT_W + 4;
  localparam int SQ_CYCLES  = ROOT_W / 2;
  localparam int SQ_CNT_W   = $clog2(SQ_CYCLES);

  // divider: quotient bit pairs per cycle
  localparam int DEN_W      = 37;
  localparam int NUM_W      = 56;
  localparam int DIV_REM_W  = DEN_W + 1;
  localparam int DIV_CYCLES = NUM_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam int MEM_W      = 2 * VAL_W + NU_W;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_DECAY  = 2'd0,
    REG_SECOND_DECAY = 2'd1,
    REG_EPSILON      = 2'd2,
    REG_AMSGRAD_MODE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t                     op;
    logic [SLOT_W-1:0]       slot;
    logic signed [VAL_W-1:0] value;
    logic [LR_W-1:0]         learn_rate;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       out_slot;
    logic signed [VAL_W-1:0] new_coef;
    logic                    saturated;
  } rsp_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] coef;
    logic signed [VAL_W-1:0] first;
    logic [NU_W-1:0]         second;
  } slot_state_t;

  // slot folded onto the store depth, one table entry per slot code
  function automatic logic [IDX_W-1:0] slot_to_index(input logic [SLOT_W-1:0] s);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int j = 0; j < 2 ** SLOT_W; j++) begin
      if (s == SLOT_W'(j)) r = IDX_W'(j % NUM_COEFS);
    end
    return r;
  endfunction

endpackage

[rtl/adam_ram.sv]
module adam_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 2,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  input  logic              we,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/adam_sqrt.sv]
module adam_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [adam_pkg::NU_W-1:0]   radicand,
  output logic                        done,
  output logic [adam_pkg::ROOT_W-1:0] root
);

  logic                            busy;
  logic [adam_pkg::SQ_CNT_W-1:0]   cnt;
  logic [adam_pkg::SQ_IN_W-1:0]    xs;
  logic [adam_pkg::SQ_REM_W-1:0]   rem;
  logic [adam_pkg::SQ_REM_W-1:0]   rem_next;
  logic [adam_pkg::ROOT_W-1:0]     root_next;

  // two digit-recurrence steps per cycle
  always_comb begin
    logic [adam_pkg::SQ_REM_W-1:0] r;
    logic [adam_pkg::SQ_REM_W-1:0] t;
    logic [adam_pkg::ROOT_W-1:0]   q;
    r = rem;
    q = root;
    for (int k = 0; k < 2; k++) begin
      r = {r[adam_pkg::SQ_REM_W-3:0], xs[adam_pkg::SQ_IN_W-1-2*k -: 2]};
      t = adam_pkg::SQ_REM_W'({q, 2'b01});
      if (r >= t) begin
        r = r - t;
        q = {q[adam_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        q = {q[adam_pkg::ROOT_W-2:0], 1'b0};
      end
    end
    rem_next  = r;
    root_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        xs   <= {{(adam_pkg::SQ_IN_W - adam_pkg::NU_W - adam_pkg::SQ_SHIFT){1'b0}},
                 radicand, {adam_pkg::SQ_SHIFT{1'b0}}};
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        xs   <= {xs[adam_pkg::SQ_IN_W-5:0], 4'b0000};
        rem  <= rem_next;
        root <= root_next;
        cnt  <= cnt + 1'b1;
        if (cnt == adam_pkg::SQ_CNT_W'(adam_pkg::SQ_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/adam_div.sv]
module adam_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [adam_pkg::NUM_W-1:0] num,
  input  logic [adam_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [adam_pkg::NUM_W-1:0] quot
);

  logic                              busy;
  logic [adam_pkg::DIV_CNT_W-1:0]    cnt;
  logic [adam_pkg::DEN_W-1:0]        dv;
  logic [adam_pkg::DIV_REM_W-1:0]    rem;
  logic [adam_pkg::DIV_REM_W-1:0]    rem_next;
  logic [adam_pkg::NUM_W-1:0]        quot_next;

  // restoring division, two quotient bits per cycle; quot shifts the
  // numerator out and the quotient in
  always_comb begin
    logic [adam_pkg::DIV_REM_W-1:0] r;
    logic [adam_pkg::NUM_W-1:0]     q;
    r = rem;
    q = quot;
    for (int k = 0; k < 2; k++) begin
      r = {r[adam_pkg::DIV_REM_W-2:0], q[adam_pkg::NUM_W-1]};
      q = {q[adam_pkg::NUM_W-2:0], 1'b0};
      if (r >= adam_pkg::DIV_REM_W'(dv)) begin
        r    = r - adam_pkg::DIV_REM_W'(dv);
        q[0] = 1'b1;
      end
    end
    rem_next  = r;
    quot_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dv   <= den;
        rem  <= '0;
        quot <= num;
      end else if (busy) begin
        rem  <= rem_next;
        quot <= quot_next;
        cnt  <= cnt + 1'b1;
        if (cnt == adam_pkg::DIV_CNT_W'(adam_pkg::DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/adam_amsgrad_update_core.sv]
// per-coefficient adam / amsgrad update engine
// request channel in_valid/in_ready/in_data: a load request writes a coefficient
// into its slot and clears both moments; an update request applies one gradient
// element with its learning rate and returns the new coefficient
// response channel out_valid/out_ready/out_data: exactly one response per request,
// echoing the slot, with a flag set when any intermediate value clipped
// config port cfg_we/cfg_index/cfg_data: write-only, takes effect at once,
// only to be written while no request is in flight
// a load goes from ST_IDLE straight to ST_FINISH, an update through ST_RD, ST_M1
// to ST_M4, ST_SQRT and ST_DIV before ST_FINISH; the update time is set by the
// radix-4 square root and the radix-4 divider that run one after the other, plus the
// moment read-modify-write through the slot memory
// one request is worked at a time: in_ready is high only while the engine is
// free, so a new request is taken only once the last one has left ST_FINISH
// the response sits in an output register; the engine takes a new request
// while a response is still waiting, and only stalls at the end of the next
// request if that response has still not been taken
// reset (rst, synchronous) restores the decay factors, epsilon and mode to
// their defaults and empties the response register; slot contents are not
// cleared, an update must follow a load of the same slot
module adam_amsgrad_update_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  adam_pkg::req_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output adam_pkg::rsp_t                  out_data,
  input  logic                            cfg_we,
  input  logic [adam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adam_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_SQRT,
    ST_DIV,
    ST_FINISH
  } state_t;

  localparam int VW = adam_pkg::VAL_W;
  localparam int NW = adam_pkg::NU_W;

  state_t state;

  // configuration registers
  logic [adam_pkg::DECAY_W-1:0] first_decay;
  logic [adam_pkg::DECAY_W-1:0] second_decay;
  logic [adam_pkg::EPS_W-1:0]   epsilon;
  logic                         amsgrad_mode;

  // request held for the whole update
  logic [adam_pkg::SLOT_W-1:0]  slot;
  logic [adam_pkg::IDX_W-1:0]   idx;
  logic signed [VW-1:0]         val;
  logic [adam_pkg::LR_W-1:0]    lr;

  // slot memory
  logic                         accept;
  logic                         ram_we;
  logic [adam_pkg::IDX_W-1:0]   ram_addr;
  adam_pkg::slot_state_t        ram_wdata;
  logic [adam_pkg::MEM_W-1:0]   ram_rdata;
  adam_pkg::slot_state_t        cur;

  // datapath registers
  logic signed [48:0]           p1;
  logic signed [49:0]           p2;
  logic [63:0]                  g2prod;
  logic [39:0]                  g2;
  logic [63:0]                  nprod1;
  logic [56:0]                  nprod2;
  logic [adam_pkg::NUM_W-1:0]   mag;
  logic signed [VW-1:0]         rho;
  logic [NW-1:0]                nu;
  logic signed [VW-1:0]         res_coef;
  logic                         sat;

  // combinational pieces
  logic [16:0]                  c1;
  logic [16:0]                  c2;
  logic [VW-1:0]                gabs;
  logic [VW-1:0]                rho_abs;
  logic signed [50:0]           rsum;
  logic signed [34:0]           rsh;
  logic                         rho_clip;
  logic signed [VW-1:0]         rho_calc;
  logic [64:0]                  nsum;
  logic                         nu_clip;
  logic [NW-1:0]                nu_calc;
  logic [adam_pkg::DEN_W-1:0]   den_raw;
  logic [adam_pkg::DEN_W-1:0]   den;
  logic [adam_pkg::NUM_W-1:0]   num;
  logic signed [57:0]           csum;
  logic                         coef_clip;
  logic signed [VW-1:0]         coef_calc;

  // iterative units
  logic                         sqrt_start;
  logic                         sqrt_done;
  logic [adam_pkg::ROOT_W-1:0]  sqrt_root;
  logic                         div_start;
  logic                         div_done;
  logic [adam_pkg::NUM_W-1:0]   div_quot;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign cur      = adam_pkg::slot_state_t'(ram_rdata);

  // load writes at accept, update writes back when the quotient is ready
  assign ram_addr = accept ? adam_pkg::slot_to_index(in_data.slot) : idx;
  assign ram_we   = (accept && in_data.op == adam_pkg::OP_LOAD) ||
                    (state == ST_DIV && div_done);

  always_comb begin
    if (state == ST_IDLE) begin
      ram_wdata.coef   = in_data.value;
      ram_wdata.first  = '0;
      ram_wdata.second = '0;
    end else begin
      ram_wdata.coef   = coef_calc;
      ram_wdata.first  = rho;
      ram_wdata.second = nu;
    end
  end

  adam_ram #(
    .WIDTH (adam_pkg::MEM_W),
    .DEPTH (adam_pkg::NUM_COEFS),
    .ADDR_W(adam_pkg::IDX_W)
  ) u_ram (
    .clk  (clk),
    .addr (ram_addr),
    .we   (ram_we),
    .wdata(ram_wdata),
    .re   (accept),
    .rdata(ram_rdata)
  );

  // first moment: round half up of the q16 blend, then clip to 32 bits
  assign c1       = 17'h10000 - 17'(first_decay);
  assign c2       = 17'h10000 - 17'(second_decay);
  assign gabs     = val[VW-1] ? (~val + 1'b1) : val;
  assign rsum     = 51'(p1) + 51'(p2) + 51'sd32768;
  assign rsh      = rsum[50:16];
  assign rho_clip = (rsh[34:31] != 4'b0000) && (rsh[34:31] != 4'b1111);
  assign rho_calc = rho_clip ? (rsh[34] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
                             : rsh[VW-1:0];
  assign rho_abs  = rho[VW-1] ? (~rho + 1'b1) : rho;

  // second moment: blend, clip to 48 bits, running maximum in amsgrad mode
  assign nsum    = 65'(nprod1) + 65'(nprod2) + 65'd32768;
  assign nu_clip = nsum[64];
  always_comb begin
    nu_calc = nu_clip ? {NW{1'b1}} : nsum[63:16];
    if (amsgrad_mode && nu_calc < cur.second) begin
      nu_calc = cur.second;
    end
  end

  // denominator with the zero guard, numerator rounded to nearest
  assign den_raw = {sqrt_root[adam_pkg::DEN_W-6:0], 5'b00000} +
                   adam_pkg::DEN_W'(epsilon);
  assign den     = (den_raw == '0) ? adam_pkg::DEN_W'(1) : den_raw;
  assign num     = mag + adam_pkg::NUM_W'(den[adam_pkg::DEN_W-1:1]);

  // step applied against the sign of the first moment
  always_comb begin
    if (rho[VW-1]) begin
      csum = 58'(cur.coef) + $signed({2'b00, div_quot});
    end else begin
      csum = 58'(cur.coef) - $signed({2'b00, div_quot});
    end
  end
  assign coef_clip = (csum[57:31] != '0) && (csum[57:31] != '1);
  assign coef_calc = coef_clip ? (csum[57] ? {1'b1, {(VW-1){1'b0}}}
                                           : {1'b0, {(VW-1){1'b1}}})
                               : csum[VW-1:0];

  assign sqrt_start = (state == ST_M4);
  assign div_start  = (state == ST_SQRT) && sqrt_done;

  adam_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .radicand(nu_calc),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

  adam_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (den),
    .done (div_done),
    .quot (div_quot)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_decay  <= adam_pkg::DECAY_W'(58982);
      second_decay <= adam_pkg::DECAY_W'(65470);
      epsilon      <= adam_pkg::EPS_W'(1);
      amsgrad_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (adam_pkg::cfg_reg_t'(cfg_index))
        adam_pkg::REG_FIRST_DECAY:  first_decay  <= cfg_data[adam_pkg::DECAY_W-1:0];
        adam_pkg::REG_SECOND_DECAY: second_decay <= cfg_data[adam_pkg::DECAY_W-1:0];
        adam_pkg::REG_EPSILON:      epsilon      <= cfg_data[adam_pkg::EPS_W-1:0];
        adam_pkg::REG_AMSGRAD_MODE: amsgrad_mode <= cfg_data[0];
      endcase
    end
  end

  // sequencer and registered datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a response taken while the next one is ready gets replaced below
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            slot     <= in_data.slot;
            idx      <= adam_pkg::slot_to_index(in_data.slot);
            val      <= in_data.value;
            lr       <= in_data.learn_rate;
            sat      <= 1'b0;
            res_coef <= in_data.value;
            state    <= (in_data.op == adam_pkg::OP_LOAD) ? ST_FINISH : ST_RD;
          end
        end
        ST_RD: begin
          p1    <= cur.first * $signed({1'b0, first_decay});
          p2    <= val * $signed({1'b0, c1});
          state <= ST_M1;
        end
        ST_M1: begin
          rho    <= rho_calc;
          sat    <= sat | rho_clip;
          g2prod <= gabs * gabs;
          state  <= ST_M2;
        end
        ST_M2: begin
          g2     <= 40'((g2prod + 64'h80_0000) >> 24);
          nprod1 <= cur.second * 64'(second_decay);
          mag    <= adam_pkg::NUM_W'(lr) * adam_pkg::NUM_W'(rho_abs);
          state  <= ST_M3;
        end
        ST_M3: begin
          nprod2 <= g2 * 57'(c2);
          state  <= ST_M4;
        end
        ST_M4: begin
          nu    <= nu_calc;
          sat   <= sat | nu_clip;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_coef <= coef_calc;
            sat      <= sat | coef_clip;
            state    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_data.out_slot  <= slot;
            out_data.new_coef  <= res_coef;
            out_data.saturated <= sat;
            out_valid          <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sqrt_done_in_sqrt: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == ST_SQRT)
    else $error("square root finished outside its wait state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (accept || state == ST_DIV))
    else $error("slot memory written without a load or write-back");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request taken while another is in flight");

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_valid && !out_ready) |=> state == ST_FINISH)
    else $error("pending response overwritten");
`endif

endmodule
